/* hdl/mbce_pkg.sv */
// Shared types, constants and helpers for the monochrome bitmap color expander.
// Used by every module under hdl; depends on nothing else.
package mbce_pkg;

	localparam int MAX_DIMENSION = 1024;
	localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
	localparam int COLOR_W       = 16;
	localparam int BYTE_W        = 8;
	localparam int PIX_IDX_W     = $clog2(BYTE_W);
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = COLOR_W;

	localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 2'd3;

	localparam logic [COLOR_W-1:0] FORE_RESET   = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BACK_RESET   = 16'h0000;
	localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(8);
	localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(8);

	typedef struct packed {
		logic [COLOR_W-1:0] fore_color;
		logic [COLOR_W-1:0] back_color;
		logic [DIM_W-1:0]   bitmap_width;
		logic [DIM_W-1:0]   bitmap_height;
	} cfg_t;

	// One classified byte: bits, index of its last pixel, end flags for that pixel, and colors.
	typedef struct packed {
		logic [BYTE_W-1:0]    bits;
		logic [PIX_IDX_W-1:0] last_idx;
		logic                 row_end;
		logic                 bitmap_end;
		logic [COLOR_W-1:0]   fore_color;
		logic [COLOR_W-1:0]   back_color;
	} desc_t;

	// A dimension of zero counts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end
		return r;
	endfunction

endpackage

/* hdl/mbce_front.sv */
// Front end: accepts bitmap bytes, tracks column and row, classifies each byte.
// Depends on mbce_pkg.
module mbce_front (
	input  logic                clk,
	input  logic                arst_n,
	input  mbce_pkg::cfg_t      cfg,
	input  logic                byte_valid,
	input  logic [7:0]          byte_data,
	input  logic                queue_full,
	output logic                byte_ready,
	output logic                push,
	output mbce_pkg::desc_t     push_desc
);

	logic [mbce_pkg::DIM_W-1:0] col_q, row_q;
	logic [mbce_pkg::DIM_W-1:0] w, h, col_eff, row_eff, remaining;
	logic [mbce_pkg::DIM_W:0]   row_inc;
	logic                       restart, big, last_row;

	assign w = mbce_pkg::clamp_dim(cfg.bitmap_width);
	assign h = mbce_pkg::clamp_dim(cfg.bitmap_height);

	// A register write can leave the counters outside the bitmap; start a new drawing then.
	assign restart   = (col_q >= w) || (row_q >= h);
	assign col_eff   = restart ? '0 : col_q;
	assign row_eff   = restart ? '0 : row_q;
	assign remaining = w - col_eff;
	assign big       = remaining > mbce_pkg::DIM_W'(mbce_pkg::BYTE_W);
	assign row_inc   = {1'b0, row_eff} + (mbce_pkg::DIM_W+1)'(1);
	assign last_row  = row_inc == {1'b0, h};

	assign byte_ready = !queue_full;
	assign push       = byte_valid && byte_ready;

	always_comb begin
		push_desc.bits       = byte_data;
		push_desc.last_idx   = big ? mbce_pkg::PIX_IDX_W'(mbce_pkg::BYTE_W - 1)
		                           : mbce_pkg::PIX_IDX_W'(remaining - mbce_pkg::DIM_W'(1));
		push_desc.row_end    = !big;
		push_desc.bitmap_end = !big && last_row;
		push_desc.fore_color = cfg.fore_color;
		push_desc.back_color = cfg.back_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (big) begin
				col_q <= col_eff + mbce_pkg::DIM_W'(mbce_pkg::BYTE_W);
				row_q <= row_eff;
			end else begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[mbce_pkg::DIM_W-1:0];
			end
		end
	end

endmodule

/* hdl/mbce_queue.sv */
// Short descriptor queue between the front and back ends.
// Depends on mbce_pkg.
module mbce_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mbce_pkg::desc_t push_desc,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output mbce_pkg::desc_t head
);

	mbce_pkg::desc_t              slots [mbce_pkg::FIFO_DEPTH];
	logic [mbce_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [mbce_pkg::FIFO_AW:0]   count_q;

	assign full      = count_q == (mbce_pkg::FIFO_AW+1)'(mbce_pkg::FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slots[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + mbce_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + mbce_pkg::FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (mbce_pkg::FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (mbce_pkg::FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/mbce_back.sv */
// Back end: expands bytes into an output register, one pixel per cycle unless stalled.
// Depends on mbce_pkg.
module mbce_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             desc_valid,
	input  mbce_pkg::desc_t                  desc,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mbce_pkg::COLOR_W-1:0]     out_color,
	output logic                             out_row_end,
	output logic                             out_bitmap_end
);

	logic                              work_valid_q;
	logic [mbce_pkg::BYTE_W-1:0]       shift_q;
	logic [mbce_pkg::PIX_IDX_W-1:0]    left_q;
	mbce_pkg::desc_t                   cur_q;
	logic                              adv, last_pix;

	assign adv      = work_valid_q && (!out_valid || out_ready);
	assign last_pix = left_q == '0;
	assign pop      = desc_valid && (!work_valid_q || (adv && last_pix));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (pop) begin
				work_valid_q <= 1'b1;
			end else if (adv && last_pix) begin
				work_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q   <= desc;
			shift_q <= desc.bits;
			left_q  <= desc.last_idx;
		end else if (adv) begin
			shift_q <= {shift_q[mbce_pkg::BYTE_W-2:0], 1'b0};
			left_q  <= left_q - mbce_pkg::PIX_IDX_W'(1);
		end
		if (adv) begin
			out_color      <= shift_q[mbce_pkg::BYTE_W-1] ? cur_q.fore_color : cur_q.back_color;
			out_row_end    <= last_pix && cur_q.row_end;
			out_bitmap_end <= last_pix && cur_q.bitmap_end;
		end
	end

	a_bitmap_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bitmap_end |-> out_row_end)
		else $error("bitmap end flagged without row end");

	a_work_continues: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_pix |=> work_valid_q)
		else $error("byte dropped before its last pixel");

	a_work_drains: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_pix && !desc_valid |=> !work_valid_q)
		else $error("finished byte still marked busy");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> work_valid_q)
		else $error("popped descriptor not taken into work");

endmodule

/* hdl/mono_bitmap_color_expand.sv */
// Top level of the monochrome bitmap color expander.
// Holds the configuration registers; instantiates mbce_front, mbce_queue and mbce_back.
//
// Expands a 1-bit-per-pixel bitmap into RGB565 pixels. Bitmap bytes arrive as
// transactions on the s_ side in row order; each row starts on a byte boundary and
// the MSB of a byte is its leftmost pixel. A set bit gives fore_color, a clear bit
// back_color, and padding bits past the row width give no pixel. Every pixel leaves
// as one transaction on the m_ side with m_tlast high on the last pixel of a row
// and m_tuser high on the last pixel of the whole bitmap; after that byte the
// counters start the next drawing. Rate: one pixel per cycle while m_tready is high
// and bytes are queued; a full byte gives eight pixels and the end of a row fewer,
// paced by the single-pixel output register of the back end. The front end takes
// a byte per cycle while the four-entry descriptor queue has room, so input and
// output stall independently. Width and height of zero are treated as one and values
// above 1024 as 1024. The user must write registers through cfg_we/cfg_index/cfg_data
// only while no transaction is in flight; the block itself does not enforce this.
module mono_bitmap_color_expand (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Bitmap byte input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] bitmap_byte
	// Pixel output.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] pixel_color
	output logic        m_tlast,   // row_end
	output logic        m_tuser    // [0] bitmap_end
);

	mbce_pkg::cfg_t  cfg_q;
	mbce_pkg::desc_t push_desc, head;
	logic            push, pop, full, not_empty;

	// Configuration registers; width and height keep only their low eleven bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fore_color    <= mbce_pkg::FORE_RESET;
			cfg_q.back_color    <= mbce_pkg::BACK_RESET;
			cfg_q.bitmap_width  <= mbce_pkg::WIDTH_RESET;
			cfg_q.bitmap_height <= mbce_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbce_pkg::REG_FORE_COLOR:    cfg_q.fore_color <= cfg_data;
				mbce_pkg::REG_BACK_COLOR:    cfg_q.back_color <= cfg_data;
				mbce_pkg::REG_BITMAP_WIDTH:
					cfg_q.bitmap_width  <= cfg_data[mbce_pkg::DIM_W-1:0];
				mbce_pkg::REG_BITMAP_HEIGHT:
					cfg_q.bitmap_height <= cfg_data[mbce_pkg::DIM_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// The front end classifies each byte: how many pixels it holds and which end flags apply.
	mbce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (s_tvalid),
		.byte_data  (s_tdata),
		.queue_full (full),
		.byte_ready (s_tready),
		.push       (push),
		.push_desc  (push_desc)
	);

	mbce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	// The back end shifts one pixel per cycle into its output register unless m_tready stalls.
	mbce_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.desc_valid     (not_empty),
		.desc           (head),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_color      (m_tdata),
		.out_row_end    (m_tlast),
		.out_bitmap_end (m_tuser)
	);

endmodule

/* sim/tb.sv */
// Self-checking testbench for mono_bitmap_color_expand.
// Needs only the RTL under hdl (mbce_pkg, the top level and its submodules); reads and writes no files.
`timescale 1ns / 100ps

module tb;

	// The run is cut off here; the slowest correct run stays far below it.
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_ITEMS = 410;

	// One expanded pixel as it should leave the block.
	typedef struct {
		logic [mbce_pkg::COLOR_W-1:0] color;
		logic                         row_end;
		logic                         bitmap_end;
	} pixel_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	// Pixels still owed by the block, oldest first.
	pixel_t            expected_pixels[$];
	int unsigned       mismatches = 0;
	int unsigned       cycles = 0;

	// Shadow copy of the registers and of the drawing position.
	logic [mbce_pkg::COLOR_W-1:0] fore_color;
	logic [mbce_pkg::COLOR_W-1:0] back_color;
	logic [mbce_pkg::DIM_W-1:0]   width_reg;
	logic [mbce_pkg::DIM_W-1:0]   height_reg;
	int unsigned                  col_pos;
	int unsigned                  row_pos;

	// Idling controls: the source leaves gaps between bytes and the sink stalls.
	bit                 src_pause_en;
	bit                 sink_pause_en;
	int                 sink_hold;

	mono_bitmap_color_expand dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog. A hang in either handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly no gap, now and then a short one, rarely a long one.
	function automatic int idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// A stored dimension of zero acts as one, anything past the maximum as the maximum.
	function automatic int unsigned eff_dim(input logic [mbce_pkg::DIM_W-1:0] v);
		if (v == '0) return 1;
		if (v > mbce_pkg::MAX_DIMENSION) return mbce_pkg::MAX_DIMENSION;
		return 32'(v);
	endfunction

	// Works out the pixels that one bitmap byte produces and advances the position.
	// A register write can leave the position outside the new bitmap; then a new
	// drawing starts at the top left before the byte is used.
	function automatic void expand_byte(input logic [7:0] bits);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned k;
		logic        last_row;
		pixel_t      p;
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		if (col_pos >= w || row_pos >= h) begin
			col_pos = 0;
			row_pos = 0;
		end
		last_row = (row_pos + 1 == h);
		for (k = 0; k < 8; k++) begin
			col = col_pos + k;
			if (col >= w) break;
			p.color      = bits[7 - k] ? fore_color : back_color;
			p.row_end    = (col + 1 == w);
			p.bitmap_end = p.row_end && last_row;
			expected_pixels.push_back(p);
		end
		col_pos += 8;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
	endfunction

	// Sink side. m_tready changes only at the falling edge; a stall of random
	// length may start after any cycle while stalls are enabled.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_tready <= 1'b1;
			if (sink_pause_en) sink_hold = idle_gap();
		end
	end

	// Every output transaction is matched against the oldest pending pixel.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel with no expectation: pixel_color %h row_end %b bitmap_end %b",
					m_tdata, m_tlast, m_tuser);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want.color) begin
					$error("pixel_color: expected %h, got %h", want.color, m_tdata);
					mismatches++;
				end
				if (m_tlast !== want.row_end) begin
					$error("row_end: expected %b, got %b", want.row_end, m_tlast);
					mismatches++;
				end
				if (m_tuser !== want.bitmap_end) begin
					$error("bitmap_end: expected %b, got %b", want.bitmap_end, m_tuser);
					mismatches++;
				end
			end
		end
	end

	// Presents one byte and returns at the edge where it is taken. The caller
	// must follow up at once with another byte or with wait_for_drain, so that
	// s_tvalid is never left high across an edge by mistake. The prediction is
	// made when the byte is driven; since every driven byte is accepted before
	// anything else changes, that is the same as predicting on acceptance.
	task automatic send_byte(input logic [7:0] bits);
		int gap;
		gap = src_pause_en ? idle_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		expand_byte(bits);
		s_tvalid <= 1'b1;
		s_tdata  <= bits;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drops the source and waits until every predicted pixel has come out.
	// Each byte yields at least one pixel, so an empty queue means the block is
	// idle; the wait afterwards covers its output register.
	task automatic wait_for_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Single-cycle register write. Only called while the block is idle.
	task automatic write_reg(input logic [mbce_pkg::CFG_IDX_W-1:0] idx,
			input logic [mbce_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			mbce_pkg::REG_FORE_COLOR:    fore_color = data;
			mbce_pkg::REG_BACK_COLOR:    back_color = data;
			mbce_pkg::REG_BITMAP_WIDTH:  width_reg  = data[mbce_pkg::DIM_W-1:0];
			mbce_pkg::REG_BITMAP_HEIGHT: height_reg = data[mbce_pkg::DIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] random_color();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Mostly small bitmaps so that drawings complete often; now and then zero,
	// the maximum, values past it, or anything at all. The bits above the
	// register width are random and must be ignored by the block.
	function automatic logic [15:0] random_dim(input bit is_width);
		int unsigned r;
		logic [mbce_pkg::DIM_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			v = is_width ? mbce_pkg::DIM_W'($urandom_range(1, 40))
			             : mbce_pkg::DIM_W'($urandom_range(1, 6));
		end else if (r < 78) v = '0;
		else if (r < 84) v = mbce_pkg::DIM_W'(mbce_pkg::MAX_DIMENSION);
		else if (r < 90) begin
			v = mbce_pkg::DIM_W'($urandom_range(mbce_pkg::MAX_DIMENSION + 1, 2047));
		end else v = mbce_pkg::DIM_W'($urandom);
		return {5'($urandom), v};
	endfunction

	// Reset settings: an 8 x 8 bitmap, one byte per row, white on black.
	// A whole drawing covers all-clear, all-set and single-bit patterns.
	task automatic test_reset_defaults();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(8'h7E);
		send_byte(8'($urandom));
		wait_for_drain();
	endtask

	// Colors at both extremes, then changed in the middle of a drawing; the new
	// colors apply from the next byte on.
	task automatic test_color_registers();
		write_reg(mbce_pkg::REG_FORE_COLOR, 16'h0000);
		write_reg(mbce_pkg::REG_BACK_COLOR, 16'hFFFF);
		send_byte(8'hF0);
		send_byte(8'h0F);
		wait_for_drain();
		write_reg(mbce_pkg::REG_FORE_COLOR, random_color());
		write_reg(mbce_pkg::REG_BACK_COLOR, random_color());
		send_byte(8'hC3);
		wait_for_drain();
	endtask

	// A 1 x 1 bitmap: every byte gives one pixel that ends both row and bitmap.
	// Zero dimensions must behave exactly like one.
	task automatic test_tiny_dimensions();
		write_reg(mbce_pkg::REG_BITMAP_WIDTH, 16'd1);
		write_reg(mbce_pkg::REG_BITMAP_HEIGHT, 16'd1);
		send_byte(8'h80);
		send_byte(8'h7F);
		wait_for_drain();
		write_reg(mbce_pkg::REG_BITMAP_WIDTH, 16'd0);
		write_reg(mbce_pkg::REG_BITMAP_HEIGHT, 16'd0);
		send_byte(8'hFF);
		wait_for_drain();
	endtask

	// Nine pixels per row: the second byte of each row has seven padding bits
	// that give no pixel. The width write carries junk in its upper bits.
	task automatic test_row_padding();
		write_reg(mbce_pkg::REG_BITMAP_WIDTH, 16'hF809);
		write_reg(mbce_pkg::REG_BITMAP_HEIGHT, 16'd2);
		send_byte(8'hA5);
		send_byte(8'h7F);
		send_byte(8'h3C);
		send_byte(8'h80);
		wait_for_drain();
	endtask

	// Oversized dimensions clamp to the maximum. Shrinking the width below the
	// current column, and then the height below the current row, must each
	// restart the drawing at the top left.
	task automatic test_large_dimensions();
		write_reg(mbce_pkg::REG_BITMAP_WIDTH, 16'h07FF);
		write_reg(mbce_pkg::REG_BITMAP_HEIGHT, 16'h0401);
		send_byte(8'h96);
		send_byte(8'h69);
		send_byte(8'hE1);
		wait_for_drain();
		write_reg(mbce_pkg::REG_BITMAP_WIDTH, 16'd8);
		send_byte(8'h1E);
		wait_for_drain();
		write_reg(mbce_pkg::REG_BITMAP_HEIGHT, 16'd1);
		send_byte(8'hB4);
		wait_for_drain();
		write_reg(mbce_pkg::REG_BITMAP_WIDTH, 16'(mbce_pkg::MAX_DIMENSION));
		write_reg(mbce_pkg::REG_BITMAP_HEIGHT, 16'(mbce_pkg::MAX_DIMENSION));
		send_byte(8'h4B);
		send_byte(8'hD2);
		wait_for_drain();
	endtask

	// Random phases: a random subset of registers is rewritten while idle, then
	// mostly whole drawings are sent, sometimes just a few bytes so that the
	// next phase starts in the middle of a drawing. Idling on each side is
	// switched on or off per phase so that both busy and bursty stretches occur.
	task automatic test_random_drawings();
		int unsigned sent;
		int unsigned n;
		int unsigned per_drawing;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_for_drain();
			src_pause_en  = ($urandom_range(0, 3) != 0);
			sink_pause_en = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1) != 0) begin
				write_reg(mbce_pkg::REG_FORE_COLOR, random_color());
			end
			if ($urandom_range(0, 1) != 0) begin
				write_reg(mbce_pkg::REG_BACK_COLOR, random_color());
			end
			if ($urandom_range(0, 2) != 0) begin
				write_reg(mbce_pkg::REG_BITMAP_WIDTH, random_dim(1'b1));
			end
			if ($urandom_range(0, 2) != 0) begin
				write_reg(mbce_pkg::REG_BITMAP_HEIGHT, random_dim(1'b0));
			end
			per_drawing = ((eff_dim(width_reg) + 7) / 8) * eff_dim(height_reg);
			if ($urandom_range(0, 9) < 7) n = per_drawing * $urandom_range(1, 3);
			else n = $urandom_range(1, 20);
			if (n > 150) n = 150;
			if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
			repeat (n) send_byte(8'($urandom));
			sent += n;
		end
		wait_for_drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = mbce_pkg::REG_FORE_COLOR;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		sink_hold     = 0;
		src_pause_en  = 1'b1;
		sink_pause_en = 1'b1;
		fore_color    = 16'hFFFF;
		back_color    = 16'h0000;
		width_reg     = mbce_pkg::DIM_W'(8);
		height_reg    = mbce_pkg::DIM_W'(8);
		col_pos       = 0;
		row_pos       = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_color_registers();
		test_tiny_dimensions();
		test_row_padding();
		test_large_dimensions();
		test_random_drawings();

		// Give a stray late pixel time to show up before the verdict.
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/mbce_pkg.sv
hdl/mbce_front.sv
hdl/mbce_queue.sv
hdl/mbce_back.sv
hdl/mono_bitmap_color_expand.sv
sim/tb.sv
